FILE: hw/rtl/msort_pkg.sv
// Shared constants, state encoding and control types of the merge sorter.
package msort_pkg;

    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SEG   = 7'b0000010,
        S_LA    = 7'b0000100,
        S_LB    = 7'b0001000,
        S_MERGE = 7'b0010000,
        S_FILL  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    // Memory control from the sequencer; the write bank is always the one not read.
    typedef struct packed {
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic [ADDR_BITS-1:0] wr_addr;
        logic                 src;
    } t_mem_ctl;

endpackage

FILE: hw/rtl/msort_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/msort_seq.sv
// Merge-pass sequencer: bottom-up ping-pong merges through one comparator, then readout.
module msort_seq (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_go,
    input  logic [msort_pkg::CNT_BITS-1:0]         i_n,
    input  logic signed [msort_pkg::VALUE_BITS-1:0] i_rdata,
    output msort_pkg::t_mem_ctl                    o_ctl,
    output logic signed [msort_pkg::VALUE_BITS-1:0] o_wr_data,
    output logic                                   o_busy,
    output logic                                   o_strobe,
    output logic                                   o_last_out
);

    localparam int CB = msort_pkg::CNT_BITS;
    localparam int AB = msort_pkg::ADDR_BITS;

    msort_pkg::t_state r_state, n_state;
    logic [CB-1:0] r_n, n_n;
    logic [CB-1:0] r_width, n_width;
    logic [CB-1:0] r_lo, n_lo;
    logic [CB-1:0] r_a, n_a;
    logic [CB-1:0] r_mid, n_mid;
    logic [CB-1:0] r_b, n_b;
    logic [CB-1:0] r_hi, n_hi;
    logic [CB-1:0] r_k, n_k;
    logic          r_src, n_src;
    logic          r_sel_a, n_sel_a;
    logic          r_strobe, n_strobe;
    logic          r_last, n_last;
    logic signed [msort_pkg::VALUE_BITS-1:0] r_head_a, n_head_a;
    logic signed [msort_pkg::VALUE_BITS-1:0] r_head_b, n_head_b;

    logic [CB:0]   mid_sum, hi_sum, n_ext, w2;
    logic [CB-1:0] mid_c, hi_c, a_inc, b_inc, k_inc;
    logic          a_ok, b_ok, take_a;
    msort_pkg::t_mem_ctl ctl;

    assign n_ext   = {1'b0, r_n};
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_width};
    assign hi_sum  = {1'b0, r_lo} + {r_width, 1'b0};
    assign w2      = {r_width, 1'b0};
    assign mid_c   = (mid_sum > n_ext) ? r_n : mid_sum[CB-1:0];
    assign hi_c    = (hi_sum > n_ext) ? r_n : hi_sum[CB-1:0];
    assign a_inc   = r_a + 1'b1;
    assign b_inc   = r_b + 1'b1;
    assign k_inc   = r_k + 1'b1;
    assign a_ok    = (r_a < r_mid);
    assign b_ok    = (r_b < r_hi);
    // On a tie the left run wins, which keeps the sort stable.
    assign take_a  = a_ok && (!b_ok || (r_head_a <= r_head_b));

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_width  = r_width;
        n_lo     = r_lo;
        n_a      = r_a;
        n_mid    = r_mid;
        n_b      = r_b;
        n_hi     = r_hi;
        n_k      = r_k;
        n_src    = r_src;
        n_sel_a  = r_sel_a;
        n_strobe = 1'b0;
        n_last   = 1'b0;
        n_head_a = r_head_a;
        n_head_b = r_head_b;
        ctl          = '0;
        ctl.src      = r_src;
        ctl.wr_addr  = r_k[AB-1:0];
        o_wr_data    = take_a ? r_head_a : r_head_b;

        case (r_state)
            msort_pkg::S_IDLE: begin
                if (i_go) begin
                    n_n     = i_n;
                    n_src   = 1'b0;
                    n_width = CB'(1);
                    n_lo    = '0;
                    n_k     = '0;
                    n_state = (i_n == CB'(1)) ? msort_pkg::S_OUT : msort_pkg::S_SEG;
                end
            end
            msort_pkg::S_SEG: begin
                n_a         = r_lo;
                n_mid       = mid_c;
                n_b         = mid_c;
                n_hi        = hi_c;
                n_k         = r_lo;
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = r_lo[AB-1:0];
                n_state     = msort_pkg::S_LA;
            end
            msort_pkg::S_LA: begin
                n_head_a    = i_rdata;
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = r_b[AB-1:0];
                n_state     = msort_pkg::S_LB;
            end
            msort_pkg::S_LB: begin
                n_head_b = i_rdata;
                n_state  = msort_pkg::S_MERGE;
            end
            msort_pkg::S_MERGE: begin
                if (!a_ok && !b_ok) begin
                    if (r_hi == r_n) begin
                        // Pass complete: the written bank becomes the source.
                        n_src   = !r_src;
                        n_width = w2[CB-1:0];
                        n_lo    = '0;
                        n_k     = '0;
                        n_state = (w2 >= n_ext) ? msort_pkg::S_OUT : msort_pkg::S_SEG;
                    end else begin
                        n_lo    = r_hi;
                        n_state = msort_pkg::S_SEG;
                    end
                end else begin
                    ctl.wr_en   = 1'b1;
                    n_k         = k_inc;
                    ctl.rd_en   = 1'b1;
                    n_sel_a     = take_a;
                    if (take_a) begin
                        n_a         = a_inc;
                        ctl.rd_addr = a_inc[AB-1:0];
                    end else begin
                        n_b         = b_inc;
                        ctl.rd_addr = b_inc[AB-1:0];
                    end
                    n_state = msort_pkg::S_FILL;
                end
            end
            msort_pkg::S_FILL: begin
                if (r_sel_a) begin
                    n_head_a = i_rdata;
                end else begin
                    n_head_b = i_rdata;
                end
                n_state = msort_pkg::S_MERGE;
            end
            msort_pkg::S_OUT: begin
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = r_k[AB-1:0];
                n_k         = k_inc;
                n_strobe    = 1'b1;
                n_last      = (k_inc == r_n);
                if (k_inc == r_n) begin
                    n_state = msort_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = msort_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= msort_pkg::S_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            r_src    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_last   <= n_last;
            r_src    <= n_src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_width  <= n_width;
        r_lo     <= n_lo;
        r_a      <= n_a;
        r_mid    <= n_mid;
        r_b      <= n_b;
        r_hi     <= n_hi;
        r_k      <= n_k;
        r_sel_a  <= n_sel_a;
        r_head_a <= n_head_a;
        r_head_b <= n_head_b;
    end

    assign o_ctl      = ctl;
    assign o_busy     = (r_state != msort_pkg::S_IDLE);
    assign o_strobe   = r_strobe;
    assign o_last_out = r_last;

    a_strobe_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == msort_pkg::S_OUT))
        else $error("result strobe without a readout cycle before it");

    a_go_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |-> (r_state == msort_pkg::S_IDLE))
        else $error("sort started while the sequencer was busy");

    a_run_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msort_pkg::S_MERGE) |-> ((r_a <= r_mid) && (r_b <= r_hi) && (r_hi <= r_n)))
        else $error("merge run pointer beyond its run");

    a_write_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.wr_en |-> (r_k < r_n))
        else $error("merge write beyond the set");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_last) |-> (r_state == msort_pkg::S_IDLE))
        else $error("final result while the sequencer is still busy");

endmodule

FILE: hw/rtl/merge_sorter_core.sv
// Top level of the merge sorter: load path, two element banks and the merge sequencer.
//
//   channel   direction  signals                                   handshake
//   command   in         start, i_value, i_last                    start && !busy
//   result    out        o_strobe, o_sorted_value, o_last_out      o_strobe, one cycle
//
// An item loads whenever start is high while busy is low. The item that ends a set
// (last flag, or the DEPTH-th item) starts ceil(log2 n) merge passes over two banks,
// each reading one element at a time on the single memory read port, then a readout
// with one result per cycle. busy stays high meanwhile.
// Reset clears the fill count and the sequencer; the banks are not cleared.
// The receiver cannot stall: every result is shown for exactly one cycle.
module merge_sorter_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    input  logic signed [msort_pkg::VALUE_BITS-1:0] i_value,
    input  logic                                   i_last,
    output logic                                   busy,
    output logic                                   o_strobe,
    output logic signed [msort_pkg::VALUE_BITS-1:0] o_sorted_value,
    output logic                                   o_last_out
);

    localparam int CB = msort_pkg::CNT_BITS;
    localparam int AB = msort_pkg::ADDR_BITS;
    localparam int VB = msort_pkg::VALUE_BITS;

    logic [CB-1:0] r_count, n_count;
    logic          accept, ends;
    logic [CB-1:0] set_n;

    msort_pkg::t_mem_ctl ctl;
    logic signed [VB-1:0] seq_wdata, rdata;
    logic [VB-1:0] rd0, rd1;
    logic          we0, we1, re0, re1;
    logic [AB-1:0] waddr0;
    logic [VB-1:0] wdata0;
    logic          seq_busy;

    assign accept = start && !seq_busy;
    assign set_n  = r_count + 1'b1;
    assign ends   = i_last || (r_count == CB'(msort_pkg::DEPTH - 1));

    always_comb begin
        n_count = r_count;
        if (accept) begin
            n_count = ends ? '0 : set_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Bank 0 also takes the loaded items; loading and merging never overlap.
    assign we0    = accept || (ctl.wr_en && ctl.src);
    assign waddr0 = accept ? r_count[AB-1:0] : ctl.wr_addr;
    assign wdata0 = accept ? i_value : seq_wdata;
    assign we1    = ctl.wr_en && !ctl.src;
    assign re0    = ctl.rd_en && !ctl.src;
    assign re1    = ctl.rd_en && ctl.src;
    assign rdata  = ctl.src ? rd1 : rd0;

    msort_ram #(.WIDTH(VB), .DEPTH(msort_pkg::DEPTH)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr0),
        .i_wdata (wdata0),
        .i_re    (re0),
        .i_raddr (ctl.rd_addr),
        .o_rdata (rd0)
    );

    msort_ram #(.WIDTH(VB), .DEPTH(msort_pkg::DEPTH)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (ctl.wr_addr),
        .i_wdata (seq_wdata),
        .i_re    (re1),
        .i_raddr (ctl.rd_addr),
        .o_rdata (rd1)
    );

    msort_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (accept && ends),
        .i_n        (set_n),
        .i_rdata    (rdata),
        .o_ctl      (ctl),
        .o_wr_data  (seq_wdata),
        .o_busy     (seq_busy),
        .o_strobe   (o_strobe),
        .o_last_out (o_last_out)
    );

    assign busy           = seq_busy;
    assign o_sorted_value = rdata;

endmodule

FILE: test/merge_sorter_checker.sv
// Checker for the merge sorter: predicts each sorted set and compares the result stream.
`timescale 1ns / 1ps

module merge_sorter_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    input  logic                                    busy,
    input  logic signed [msort_pkg::VALUE_BITS-1:0] i_value,
    input  logic                                    i_last,
    input  logic                                    o_strobe,
    input  logic signed [msort_pkg::VALUE_BITS-1:0] o_sorted_value,
    input  logic                                    o_last_out,
    output int                                      o_fail_count,
    output int                                      o_pending,
    output int                                      o_compared
);
    import msort_pkg::*;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         last;
    } t_sorted_elem;

    logic signed [VALUE_BITS-1:0] set_values [DEPTH];
    int                           set_size;
    t_sorted_elem                 sorted_q [$];
    int                           fail_n;
    int                           compared_n;

    // Stable ascending insertion sort of the held set; equal values keep arrival order.
    task automatic queue_sorted_set();
        logic signed [VALUE_BITS-1:0] work [DEPTH];
        logic signed [VALUE_BITS-1:0] key;
        t_sorted_elem                 elem;
        int                           i;
        int                           j;
        for (i = 0; i < set_size; i++) work[i] = set_values[i];
        for (i = 1; i < set_size; i++) begin
            key = work[i];
            j = i - 1;
            while (j >= 0 && work[j] > key) begin
                work[j + 1] = work[j];
                j--;
            end
            work[j + 1] = key;
        end
        for (i = 0; i < set_size; i++) begin
            elem.value = work[i];
            elem.last  = (i == set_size - 1);
            sorted_q.push_back(elem);
        end
    endtask

    always @(posedge i_clk) begin
        t_sorted_elem want;
        if (!i_rst_n) begin
            set_size   = 0;
            fail_n     = 0;
            compared_n = 0;
            sorted_q.delete();
        end else begin
            if (start && !busy) begin
                set_values[set_size] = i_value;
                set_size++;
                // A full store ends the set even without the last flag.
                if (i_last || set_size == DEPTH) begin
                    queue_sorted_set();
                    set_size = 0;
                end
            end
            if (o_strobe) begin
                if (sorted_q.size() == 0) begin
                    fail_n++;
                    $display("%0t: unexpected result, got value %0d last %0b",
                             $time, o_sorted_value, o_last_out);
                end else begin
                    want = sorted_q.pop_front();
                    compared_n++;
                    if (o_sorted_value !== want.value) begin
                        fail_n++;
                        $display("%0t: sorted_value expected %0d, got %0d",
                                 $time, want.value, o_sorted_value);
                    end
                    if (o_last_out !== want.last) begin
                        fail_n++;
                        $display("%0t: last_out expected %0b, got %0b",
                                 $time, want.last, o_last_out);
                    end
                end
            end
        end
        o_fail_count <= fail_n;
        o_pending    <= sorted_q.size();
        o_compared   <= compared_n;
    end

endmodule

FILE: test/merge_sorter_core_tb.sv
// Testbench top for the merge sorter: drives sets of values and reports the verdict.
`timescale 1ns / 1ps

module merge_sorter_core_tb;
    import msort_pkg::*;

    localparam int RANDOM_ITEMS = 380;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         start;
    logic signed [VALUE_BITS-1:0] i_value;
    logic                         i_last;
    logic                         busy;
    logic                         o_strobe;
    logic signed [VALUE_BITS-1:0] o_sorted_value;
    logic                         o_last_out;
    int                           fail_count;
    int                           pending;
    int                           compared;
    int                           items_sent;
    int                           sets_sent;
    int                           idle_pct;

    always #5 i_clk = ~i_clk;

    merge_sorter_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_value        (i_value),
        .i_last         (i_last),
        .busy           (busy),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out)
    );

    merge_sorter_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_compared     (compared)
    );

    // Offers one item, idling at random first, and returns at the edge that takes it.
    task automatic send_item(input logic signed [VALUE_BITS-1:0] value, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            i_value <= $urandom;
            i_last <= $urandom_range(0, 1);
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= value;
        i_last  <= last;
        // busy read here is the value from before the edge.
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (last) sets_sent++;
    endtask

    // Mix of full-range values, narrow ranges that force ties, and the extremes.
    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $signed($urandom_range(0, 8)) - 4;
            1: return {1'b1, {(VALUE_BITS - 1){1'b0}}};
            2: return {1'b0, {(VALUE_BITS - 1){1'b1}}};
            3: return $signed($urandom_range(0, 200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int set_len;
        int k;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_value    <= '0;
        i_last     <= 1'b0;
        items_sent = 0;
        sets_sent  = 0;
        idle_pct   = 38;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A single element, then the extremes with ties, then a reversed pair.
        send_item(32'sh7fffffff, 1'b1);
        send_item(32'sh00000000, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sh80000000, 1'b0);
        send_item(32'sh7fffffff, 1'b0);
        send_item(32'sd1, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sh80000000, 1'b0);
        send_item(32'sh7fffffff, 1'b1);
        send_item(32'sd5, 1'b0);
        send_item(-32'sd5, 1'b1);

        // An overlong set: the 64th item closes it and the rest form a new set.
        for (k = 0; k < DEPTH + 2; k++) send_item(1000 - k / 2, k == DEPTH + 1);
        sets_sent++;

        for (k = 0; k < RANDOM_ITEMS; ) begin
            idle_pct = (k < RANDOM_ITEMS / 3) ? 38 : (k < 2 * RANDOM_ITEMS / 3) ? 77 : 0;
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 6)
                                                  : $urandom_range(1, 12);
            if (set_len > DEPTH) sets_sent++;
            for (int n = 0; n < set_len; n++) begin
                send_item(pick_value(), n == set_len - 1);
                k++;
            end
        end
        start <= 1'b0;
        // Let the checker register the last set before its backlog is read.
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d items in %0d sets of 1 to %0d values (overlong sets included).",
                 items_sent, sets_sent, DEPTH + 6);
        $display("Compared %0d sorted results across three sender idling phases.", compared);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
